>>> design/pclut_pkg.sv
// shared types and constants for the palette color lookup table
package pclut_pkg;

   localparam int ENTRIES = 256;
   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int PTR_W = 9;
   localparam int RGB_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [PTR_W-1:0] RUN_MAX = PTR_W'(256);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(256);
   localparam logic [PTR_W-1:0] ENTRY_LIMIT = PTR_W'(ENTRIES);

   localparam logic [14:0] LUMA_R = 15'h4ccc;
   localparam logic [15:0] LUMA_G = 16'h970a;
   localparam logic [12:0] LUMA_B = 13'h1c29;

   localparam logic [7:0] MID_GRAY = 8'd127;
   localparam logic [RGB_W-1:0] MID_GRAY_RGB = {MID_GRAY, MID_GRAY, MID_GRAY};

   localparam logic [CSR_INDEX_W-1:0] REG_LUMINANCE_MAP = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_DIRECT_COLOUR = 1'b1;

   typedef enum logic [1:0] {
      MODE_SEQ    = 2'd0,
      MODE_IDX    = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_REFUSED = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_WRITE  = 2'd1,
      OP_FAIL   = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        first;
      logic [7:0]  index;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic        has_result;
      op_kind_type kind;
      status_type  status;
      logic [ADDR_W-1:0] addr;
   } op_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [RGB_W-1:0]  data;
   } mem_wr_type;

endpackage

>>> design/pclut_table.sv
// color table memory with per-entry valid bits standing in for the mid-gray reset
module pclut_table (
   input  logic                          clock,
   input  logic                          reset,
   input  pclut_pkg::mem_wr_type         wr,
   input  logic                          rd_en,
   input  logic [pclut_pkg::ADDR_W-1:0]  rd_addr,
   output logic [pclut_pkg::RGB_W-1:0]   rd_data
);

   logic [pclut_pkg::RGB_W-1:0] mem [pclut_pkg::ENTRIES];
   logic [pclut_pkg::ENTRIES-1:0] valid_ff;
   logic [pclut_pkg::RGB_W-1:0] q_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? q_ff : pclut_pkg::MID_GRAY_RGB;

endmodule

>>> design/pclut_ctrl.sv
// item decode with write pointer and run length tracking
module pclut_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  pclut_pkg::req_type  req,
   input  logic                direct_colour,
   output pclut_pkg::op_type   op
);

   logic [pclut_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic [pclut_pkg::PTR_W-1:0] run_ff, run_in;
   logic [pclut_pkg::PTR_W-1:0] ptr_cur, run_cur, target, idx_wide;
   pclut_pkg::mode_type mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         run_ff <= '0;
      end else if (accept) begin
         ptr_ff <= ptr_in;
         run_ff <= run_in;
      end
   end

   always_comb begin
      mode = pclut_pkg::mode_type'(req.mode);
      idx_wide = pclut_pkg::PTR_W'(req.index);
      ptr_in = ptr_ff;
      run_in = run_ff;
      ptr_cur = ptr_ff;
      run_cur = run_ff;
      target = idx_wide;
      op.has_result = 1'b0;
      op.kind = pclut_pkg::OP_FAIL;
      op.status = pclut_pkg::STATUS_RANGE;
      op.addr = idx_wide[pclut_pkg::ADDR_W-1:0];
      case (mode)
         pclut_pkg::MODE_LOOKUP: begin
            op.has_result = 1'b1;
            if (idx_wide < pclut_pkg::ENTRY_LIMIT) begin
               op.kind = pclut_pkg::OP_LOOKUP;
               op.status = pclut_pkg::STATUS_OK;
            end
         end
         pclut_pkg::MODE_SEQ, pclut_pkg::MODE_IDX: begin
            op.has_result = 1'b1;
            if (direct_colour) begin
               op.status = pclut_pkg::STATUS_REFUSED;
            end else begin
               run_cur = req.first ? '0 : run_ff;
               ptr_cur = (req.first && mode == pclut_pkg::MODE_SEQ) ? idx_wide : ptr_ff;
               target = (mode == pclut_pkg::MODE_SEQ) ? ptr_cur : idx_wide;
               run_in = run_cur;
               ptr_in = ptr_cur;
               op.addr = target[pclut_pkg::ADDR_W-1:0];
               if (run_cur < pclut_pkg::RUN_MAX && target < pclut_pkg::ENTRY_LIMIT) begin
                  op.kind = pclut_pkg::OP_WRITE;
                  op.status = pclut_pkg::STATUS_OK;
                  run_in = run_cur + 1'b1;
                  if (mode == pclut_pkg::MODE_SEQ && ptr_cur < pclut_pkg::PTR_MAX) begin
                     ptr_in = ptr_cur + 1'b1;
                  end
               end
            end
         end
         default: begin
            op.has_result = 1'b0;
         end
      endcase
   end

endmodule

>>> design/palette_clut_with_luminance_map.sv
// Palette color lookup table: 256 entries of 8-bit RGB, loaded by indexed or sequential
// writes (optionally mapped to luminance gray) and read back by lookup. One word is taken
// per cycle unless a held result is stalled by rsp_stall, and its result word appears in
// the cycle after acceptance; the rate is set by the single table read port and the
// output register, which together form a two-stage path with the table write done in
// the second stage and forwarded to a lookup behind it. Every entry reads as mid-gray 127
// after reset with no clearing pass. A mode 3 word is accepted and gives no result word.
module palette_clut_with_luminance_map (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pclut_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pclut_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [pclut_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pclut_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic accept;
   logic luminance_map_ff, direct_colour_ff;
   pclut_pkg::op_type op;
   pclut_pkg::mem_wr_type mem_wr;
   logic [pclut_pkg::RGB_W-1:0] rd_data;

   logic s1_valid_ff, s1_valid_in;
   pclut_pkg::op_kind_type s1_kind_ff;
   pclut_pkg::status_type s1_status_ff;
   logic [pclut_pkg::ADDR_W-1:0] s1_addr_ff;
   logic s1_lum_ff;
   logic [pclut_pkg::RGB_W-1:0] s1_raw_ff;
   logic [22:0] pr_ff;
   logic [23:0] pg_ff;
   logic [20:0] pb_ff;
   logic fwd_ff, fwd_in;
   logic [pclut_pkg::RGB_W-1:0] fwd_rgb_ff;

   logic [24:0] luma_sum;
   logic [7:0] gray;
   logic [pclut_pkg::RGB_W-1:0] wr_rgb, out_rgb;

   assign req_stall = s1_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         luminance_map_ff <= 1'b0;
         direct_colour_ff <= 1'b0;
      end else if (csr_wr_en) begin
         if (csr_index == pclut_pkg::REG_LUMINANCE_MAP) begin
            luminance_map_ff <= csr_wr_data[0];
         end
         if (csr_index == pclut_pkg::REG_DIRECT_COLOUR) begin
            direct_colour_ff <= csr_wr_data[0];
         end
      end
   end

   pclut_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_payload),
      .direct_colour (direct_colour_ff),
      .op            (op)
   );

   always_comb begin
      luma_sum = 25'(pr_ff) + 25'(pg_ff) + 25'(pb_ff);
      gray = luma_sum[23:16];
      wr_rgb = s1_lum_ff ? {gray, gray, gray} : s1_raw_ff;
      mem_wr.en = s1_valid_ff && s1_kind_ff == pclut_pkg::OP_WRITE;
      mem_wr.addr = s1_addr_ff;
      mem_wr.data = wr_rgb;
      fwd_in = mem_wr.en && s1_addr_ff == op.addr;
      if (accept) begin
         s1_valid_in = op.has_result;
      end else if (!rsp_stall) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   pclut_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (accept && op.has_result && op.kind == pclut_pkg::OP_LOOKUP),
      .rd_addr (op.addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= op.kind;
         s1_status_ff <= op.status;
         s1_addr_ff <= op.addr;
         s1_lum_ff <= luminance_map_ff;
         s1_raw_ff <= {req_payload.red_in[15:8], req_payload.green_in[15:8],
                       req_payload.blue_in[15:8]};
         pr_ff <= 23'(req_payload.red_in[15:8]) * 23'(pclut_pkg::LUMA_R);
         pg_ff <= 24'(req_payload.green_in[15:8]) * 24'(pclut_pkg::LUMA_G);
         pb_ff <= 21'(req_payload.blue_in[15:8]) * 21'(pclut_pkg::LUMA_B);
         fwd_ff <= fwd_in;
         fwd_rgb_ff <= wr_rgb;
      end
   end

   always_comb begin
      case (s1_kind_ff)
         pclut_pkg::OP_LOOKUP: out_rgb = fwd_ff ? fwd_rgb_ff : rd_data;
         pclut_pkg::OP_WRITE:  out_rgb = wr_rgb;
         default:              out_rgb = '0;
      endcase
   end

   assign rsp_valid = s1_valid_ff;
   assign rsp_payload.status = s1_status_ff;
   assign rsp_payload.red_out = out_rgb[23:16];
   assign rsp_payload.green_out = out_rgb[15:8];
   assign rsp_payload.blue_out = out_rgb[7:0];

endmodule
